// ===== hdl/i2c_master_event_sequencer_defines.svh =====
// assertion macros shared by the sequencer rtl
`ifndef I2C_MASTER_EVENT_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_EVENT_SEQUENCER_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define SEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define SEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== hdl/i2cmes_pkg.sv =====
// types, codes and helpers for the i2c master event sequencer
package i2cmes_pkg;

    localparam int TX_DEPTH_DEF = 16;
    localparam int RX_DEPTH_DEF = 16;
    localparam int MAX_RES      = 4;

    typedef enum logic [3:0] {
        OP_START        = 4'd0,
        OP_START_SENT   = 4'd1,
        OP_TX_SELECTED  = 4'd2,
        OP_TRANSMITTING = 4'd3,
        OP_TRANSMITTED  = 4'd4,
        OP_RX_SELECTED  = 4'd5,
        OP_RECEIVED     = 4'd6,
        OP_RECEIVED_BTF = 4'd7,
        OP_LOAD         = 4'd8
    } t_opcode;

    typedef enum logic [3:0] {
        ACT_ADDR    = 4'd0,
        ACT_DATA    = 4'd1,
        ACT_START   = 4'd2,
        ACT_STOP    = 4'd3,
        ACT_ACK_OFF = 4'd4,
        ACT_ACK_ON  = 4'd5,
        ACT_BUF_ON  = 4'd6,
        ACT_BUF_OFF = 4'd7,
        ACT_EVT_OFF = 4'd8,
        ACT_RX_BYTE = 4'd9,
        ACT_TX_DONE = 4'd10,
        ACT_RX_DONE = 4'd11,
        ACT_ALL_ON  = 4'd12,
        ACT_ALL_OFF = 4'd13
    } t_action;

    typedef enum logic [2:0] {
        CFG_REMOTE_ADDRESS = 3'd0,
        CFG_SUBADDR_VALUE  = 3'd1,
        CFG_SUBADDR_BITS   = 3'd2,
        CFG_REPEAT_START   = 3'd3,
        CFG_READ_COUNT     = 3'd4,
        CFG_WRITE_COUNT    = 3'd5
    } t_cfg_index;

    typedef enum logic [6:0] {
        STEP_RESET    = 7'b0000001,
        STEP_SUBADDR  = 7'b0000010,
        STEP_RESTART  = 7'b0000100,
        STEP_READ     = 7'b0001000,
        STEP_TAIL_ACK = 7'b0010000,
        STEP_TAIL_BTF = 7'b0100000,
        STEP_DRAIN    = 7'b1000000
    } t_rx_step;

    typedef struct packed {
        t_action     action;
        logic [7:0]  byte_value;
        logic [3:0]  buffer_index;
        logic        overflow;
    } t_result;

    function automatic t_result make_res(input t_action act, input logic [7:0] val,
                                         input logic [3:0] idx, input logic ovf);
        t_result r;
        r.action       = act;
        r.byte_value   = val;
        r.buffer_index = idx;
        r.overflow     = ovf;
        return r;
    endfunction

endpackage

// ===== hdl/i2c_master_event_sequencer.sv =====
// i2c master event sequencer: turns bus events into controller commands
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+---------------------------------------------
//  in       | i_in_valid / o_in_ready    | i_opcode, i_data_byte
//  out      | o_out_valid / i_out_ready  | o_action, o_byte_value, o_buffer_index,
//           |                            | o_overflow, o_last
//  cfg      | i_cfg_we (no wait)         | i_cfg_index, i_cfg_data
//
// an item is registered, then decoded combinationally into up to four commands
// that leave through a four-entry output list, one command per cycle while
// the output is ready. a taken item passes the input register and then the
// output list before its first command shows. the list drain is the rate limit.
// reset is synchronous: counters, flags and config go to reset values, the
// transmit ring contents stay undefined. a stalled output holds the list and
// at most one waiting item.
module i2c_master_event_sequencer #(
    parameter int TX_DEPTH = i2cmes_pkg::TX_DEPTH_DEF,
    parameter int RX_DEPTH = i2cmes_pkg::RX_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [3:0]  i_opcode,
    input  logic [7:0]  i_data_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_action,
    output logic [7:0]  o_byte_value,
    output logic [3:0]  o_buffer_index,
    output logic        o_overflow,
    output logic        o_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

`include "i2c_master_event_sequencer_defines.svh"

    localparam int TXW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int RXW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam logic [TXW-1:0] TX_LAST = TXW'(TX_DEPTH - 1);
    localparam logic [RXW-1:0] RX_LAST = RXW'(RX_DEPTH - 1);
    localparam logic [8:0]     RX_CAP  = 9'(RX_DEPTH);
    localparam int MR = i2cmes_pkg::MAX_RES;

    // configuration
    logic [6:0]  r_remote_address;
    logic [31:0] r_subaddr_value;
    logic [5:0]  r_subaddr_bits;
    logic        r_repeat_start;
    logic [7:0]  r_read_count;
    logic [7:0]  r_write_count;

    // sequencing state
    i2cmes_pkg::t_rx_step r_step, n_step;
    logic [5:0]     r_sub_rem, n_sub_rem;
    logic [7:0]     r_tx_rem, n_tx_rem;
    logic [TXW-1:0] r_tx_rd_idx, n_tx_rd_idx;
    logic [TXW-1:0] r_tx_ld_idx, n_tx_ld_idx;
    logic [8:0]     r_rx_count, n_rx_count;
    logic [RXW-1:0] r_rx_wr_idx, n_rx_wr_idx;
    logic           r_ovf, n_ovf;

    // transmit ring with prefetched read of the current read slot
    logic [7:0]     r_tx_mem [TX_DEPTH];
    logic [7:0]     r_tx_rdata;
    logic [TXW-1:0] s_rd_addr;

    // input register
    logic       r_in_valid;
    logic [3:0] r_in_op;
    logic [7:0] r_in_data;

    // output list, entry 0 is the one on the port
    i2cmes_pkg::t_result r_res [MR];
    logic [2:0]          r_res_cnt;

    i2cmes_pkg::t_result s_res [MR];
    logic [2:0]          s_cnt;
    logic                s_out_acc, s_room, s_fire;
    logic                s_near_end;
    logic                s_do_sub, s_do_tx;
    logic [5:0]          s_sub_src, s_sub_rem_next, s_sub_shift;
    logic [7:0]          s_sub_byte;
    logic [7:0]          s_addr_w;
    logic [RXW-1:0]      s_slot;

    assign s_out_acc   = o_out_valid && i_out_ready;
    assign s_room      = (r_res_cnt == 3'd0) || ((r_res_cnt == 3'd1) && s_out_acc);
    assign s_fire      = r_in_valid && s_room;
    assign o_in_ready  = !r_in_valid || s_fire;
    assign o_out_valid = (r_res_cnt != 3'd0);
    assign o_action       = r_res[0].action;
    assign o_byte_value   = r_res[0].byte_value;
    assign o_buffer_index = r_res[0].buffer_index;
    assign o_overflow     = r_res[0].overflow;
    assign o_last         = (r_res_cnt == 3'd1);

    assign s_near_end = (r_read_count > 8'd2) && (r_rx_count >= 9'(r_read_count - 8'd3));
    assign s_addr_w   = {r_remote_address, 1'b0};

    // next sub-address byte: from bit remaining-8, or from bit 0 when short
    assign s_sub_src   = (r_in_op == i2cmes_pkg::OP_TX_SELECTED) ? r_subaddr_bits : r_sub_rem;
    assign s_sub_shift = s_sub_src - 6'd8;
    always_comb begin
        if (s_sub_src >= 6'd8) begin
            s_sub_byte     = 8'(r_subaddr_value >> s_sub_shift);
            s_sub_rem_next = s_sub_shift;
        end else begin
            s_sub_byte     = r_subaddr_value[7:0];
            s_sub_rem_next = 6'd0;
        end
    end

    always_comb begin
        n_step      = r_step;
        n_sub_rem   = r_sub_rem;
        n_tx_rem    = r_tx_rem;
        n_tx_rd_idx = r_tx_rd_idx;
        n_tx_ld_idx = r_tx_ld_idx;
        n_rx_count  = r_rx_count;
        n_rx_wr_idx = r_rx_wr_idx;
        n_ovf       = r_ovf;
        s_cnt       = 3'd0;
        s_do_sub    = 1'b0;
        s_do_tx     = 1'b0;
        s_slot      = r_rx_wr_idx;
        for (int k = 0; k < MR; k++) begin
            s_res[k] = '0;
        end

        case (r_in_op)
            i2cmes_pkg::OP_START: begin
                n_step     = i2cmes_pkg::STEP_RESET;
                n_sub_rem  = 6'd0;
                n_rx_count = 9'd0;
                n_ovf      = 1'b0;
                n_tx_rem   = r_write_count;
                if (r_read_count != 8'd0) begin
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_ACK_ON,
                                                             8'd0, 4'd0, n_ovf);
                    s_cnt = s_cnt + 3'd1;
                end
                s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_ALL_ON,
                                                         8'd0, 4'd0, n_ovf);
                s_cnt = s_cnt + 3'd1;
                s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_START,
                                                         8'd0, 4'd0, n_ovf);
                s_cnt = s_cnt + 3'd1;
            end
            i2cmes_pkg::OP_START_SENT: begin
                if (r_read_count != 8'd0) begin
                    if (r_repeat_start && (r_step == i2cmes_pkg::STEP_RESET)) begin
                        n_step = i2cmes_pkg::STEP_SUBADDR;
                        s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_ADDR,
                                                                 s_addr_w, 4'd0, n_ovf);
                    end else begin
                        n_step = i2cmes_pkg::STEP_READ;
                        s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_ADDR,
                                                                 s_addr_w | 8'd1, 4'd0,
                                                                 n_ovf);
                    end
                end else begin
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_ADDR,
                                                             s_addr_w, 4'd0, n_ovf);
                end
                s_cnt = s_cnt + 3'd1;
            end
            i2cmes_pkg::OP_TX_SELECTED: begin
                if ((r_read_count != 8'd0) && (r_step == i2cmes_pkg::STEP_SUBADDR)) begin
                    s_do_sub = 1'b1;
                end else begin
                    s_do_tx = 1'b1;
                end
            end
            i2cmes_pkg::OP_TRANSMITTING: begin
                if (r_read_count != 8'd0) begin
                    s_do_sub = (r_step == i2cmes_pkg::STEP_SUBADDR) && (r_sub_rem != 6'd0);
                end else begin
                    s_do_tx = 1'b1;
                end
            end
            i2cmes_pkg::OP_TRANSMITTED: begin
                if (r_read_count != 8'd0) begin
                    if (r_step == i2cmes_pkg::STEP_SUBADDR) begin
                        if (r_sub_rem == 6'd0) begin
                            n_step = i2cmes_pkg::STEP_RESTART;
                            s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(
                                i2cmes_pkg::ACT_START, 8'd0, 4'd0, n_ovf);
                            s_cnt = s_cnt + 3'd1;
                        end else begin
                            s_do_sub = 1'b1;
                        end
                    end
                end else if (r_tx_rem == 8'd0) begin
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_STOP,
                                                             8'd0, 4'd0, n_ovf);
                    s_cnt = s_cnt + 3'd1;
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_EVT_OFF,
                                                             8'd0, 4'd0, n_ovf);
                    s_cnt = s_cnt + 3'd1;
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_TX_DONE,
                                                             8'd0, 4'd0, n_ovf);
                    s_cnt = s_cnt + 3'd1;
                end else begin
                    s_do_tx = 1'b1;
                end
            end
            i2cmes_pkg::OP_RX_SELECTED: begin
                s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_BUF_ON,
                                                         8'd0, 4'd0, n_ovf);
                s_cnt = s_cnt + 3'd1;
                if (r_read_count == 8'd1) begin
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_ACK_OFF,
                                                             8'd0, 4'd0, n_ovf);
                    s_cnt = s_cnt + 3'd1;
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_STOP,
                                                             8'd0, 4'd0, n_ovf);
                    s_cnt = s_cnt + 3'd1;
                end
            end
            i2cmes_pkg::OP_RECEIVED: begin
                if (s_near_end && (r_step == i2cmes_pkg::STEP_READ)) begin
                    // third byte from the end: wait for the bus-hold event
                    n_step = i2cmes_pkg::STEP_TAIL_ACK;
                end else if (!s_near_end || (r_step == i2cmes_pkg::STEP_DRAIN)) begin
                    s_slot      = n_rx_wr_idx;
                    n_rx_wr_idx = (n_rx_wr_idx == RX_LAST) ? '0 : n_rx_wr_idx + 1'b1;
                    if (n_rx_count != 9'h1FF) n_rx_count = n_rx_count + 9'd1;
                    if (n_rx_count > RX_CAP) n_ovf = 1'b1;
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_RX_BYTE,
                                                             r_in_data, 4'(s_slot), n_ovf);
                    s_cnt = s_cnt + 3'd1;
                    if (n_rx_count == {1'b0, r_read_count}) begin
                        s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_RX_DONE,
                                                                 8'd0, 4'd0, n_ovf);
                        s_cnt = s_cnt + 3'd1;
                        s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_ALL_OFF,
                                                                 8'd0, 4'd0, n_ovf);
                        s_cnt = s_cnt + 3'd1;
                    end
                end
            end
            i2cmes_pkg::OP_RECEIVED_BTF: begin
                if (s_near_end && ((r_step == i2cmes_pkg::STEP_TAIL_ACK) ||
                                   (r_step == i2cmes_pkg::STEP_TAIL_BTF))) begin
                    if (r_step == i2cmes_pkg::STEP_TAIL_ACK) begin
                        s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_ACK_OFF,
                                                                 8'd0, 4'd0, n_ovf);
                        s_cnt = s_cnt + 3'd1;
                        s_slot      = n_rx_wr_idx;
                        n_rx_wr_idx = (n_rx_wr_idx == RX_LAST) ? '0 : n_rx_wr_idx + 1'b1;
                        if (n_rx_count != 9'h1FF) n_rx_count = n_rx_count + 9'd1;
                        if (n_rx_count > RX_CAP) n_ovf = 1'b1;
                        s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_RX_BYTE,
                                                                 r_in_data, 4'(s_slot),
                                                                 n_ovf);
                        s_cnt = s_cnt + 3'd1;
                    end
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_STOP,
                                                             8'd0, 4'd0, n_ovf);
                    s_cnt = s_cnt + 3'd1;
                    s_slot      = n_rx_wr_idx;
                    n_rx_wr_idx = (n_rx_wr_idx == RX_LAST) ? '0 : n_rx_wr_idx + 1'b1;
                    if (n_rx_count != 9'h1FF) n_rx_count = n_rx_count + 9'd1;
                    if (n_rx_count > RX_CAP) n_ovf = 1'b1;
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_RX_BYTE,
                                                             r_in_data, 4'(s_slot), n_ovf);
                    s_cnt  = s_cnt + 3'd1;
                    n_step = i2cmes_pkg::STEP_DRAIN;
                end
            end
            i2cmes_pkg::OP_LOAD: begin
                n_tx_ld_idx = (r_tx_ld_idx == TX_LAST) ? '0 : r_tx_ld_idx + 1'b1;
            end
            default: begin
            end
        endcase

        // sub-address byte or transmit ring byte; each is a whole command list
        if (s_do_sub) begin
            n_sub_rem = s_sub_rem_next;
            s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_DATA,
                                                     s_sub_byte, 4'd0, n_ovf);
            s_cnt = s_cnt + 3'd1;
            if (s_sub_rem_next == 6'd0) begin
                s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_BUF_OFF,
                                                         8'd0, 4'd0, n_ovf);
                s_cnt = s_cnt + 3'd1;
            end
        end
        if (s_do_tx) begin
            if (r_tx_rem != 8'd0) begin
                s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_DATA,
                                                         r_tx_rdata, 4'd0, n_ovf);
                s_cnt       = s_cnt + 3'd1;
                n_tx_rd_idx = (r_tx_rd_idx == TX_LAST) ? '0 : r_tx_rd_idx + 1'b1;
                n_tx_rem    = r_tx_rem - 8'd1;
                if (n_tx_rem == 8'd0) begin
                    s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_BUF_OFF,
                                                             8'd0, 4'd0, n_ovf);
                    s_cnt = s_cnt + 3'd1;
                end
            end else begin
                s_res[s_cnt[1:0]] = i2cmes_pkg::make_res(i2cmes_pkg::ACT_BUF_OFF,
                                                         8'd0, 4'd0, n_ovf);
                s_cnt = s_cnt + 3'd1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remote_address <= 7'd0;
            r_subaddr_value  <= 32'd0;
            r_subaddr_bits   <= 6'd8;
            r_repeat_start   <= 1'b0;
            r_read_count     <= 8'd0;
            r_write_count    <= 8'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                i2cmes_pkg::CFG_REMOTE_ADDRESS: r_remote_address <= i_cfg_data[6:0];
                i2cmes_pkg::CFG_SUBADDR_VALUE:  r_subaddr_value  <= i_cfg_data;
                i2cmes_pkg::CFG_SUBADDR_BITS:   r_subaddr_bits   <= i_cfg_data[5:0];
                i2cmes_pkg::CFG_REPEAT_START:   r_repeat_start   <= i_cfg_data[0];
                i2cmes_pkg::CFG_READ_COUNT:     r_read_count     <= i_cfg_data[7:0];
                i2cmes_pkg::CFG_WRITE_COUNT:    r_write_count    <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op   <= i_opcode;
            r_in_data <= i_data_byte;
        end
    end

    // sequencing state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= i2cmes_pkg::STEP_RESET;
            r_sub_rem   <= 6'd0;
            r_tx_rem    <= 8'd0;
            r_tx_rd_idx <= '0;
            r_tx_ld_idx <= '0;
            r_rx_count  <= 9'd0;
            r_rx_wr_idx <= '0;
            r_ovf       <= 1'b0;
        end else if (s_fire) begin
            r_step      <= n_step;
            r_sub_rem   <= n_sub_rem;
            r_tx_rem    <= n_tx_rem;
            r_tx_rd_idx <= n_tx_rd_idx;
            r_tx_ld_idx <= n_tx_ld_idx;
            r_rx_count  <= n_rx_count;
            r_rx_wr_idx <= n_rx_wr_idx;
            r_ovf       <= n_ovf;
        end
    end

    // transmit ring; a load into the slot about to be read bypasses the array
    assign s_rd_addr = s_fire ? n_tx_rd_idx : r_tx_rd_idx;

    always_ff @(posedge i_clk) begin
        if (s_fire && (r_in_op == i2cmes_pkg::OP_LOAD)) begin
            r_tx_mem[r_tx_ld_idx] <= r_in_data;
        end
        if (s_fire && (r_in_op == i2cmes_pkg::OP_LOAD) && (r_tx_ld_idx == s_rd_addr)) begin
            r_tx_rdata <= r_in_data;
        end else begin
            r_tx_rdata <= r_tx_mem[s_rd_addr];
        end
    end

    // output list
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= 3'd0;
        end else if (s_fire) begin
            r_res_cnt <= s_cnt;
        end else if (s_out_acc) begin
            r_res_cnt <= r_res_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            for (int k = 0; k < MR; k++) begin
                r_res[k] <= s_res[k];
            end
        end else if (s_out_acc) begin
            for (int k = 0; k < MR - 1; k++) begin
                r_res[k] <= r_res[k + 1];
            end
        end
    end

    `SEQ_ASSERT_NEXT(a_start_clears, s_fire && (r_in_op == i2cmes_pkg::OP_START), (r_rx_count == 9'd0) && !r_ovf && (r_tx_rem == $past(r_write_count)), "start did not clear the receive counters")
    `SEQ_ASSERT_NOW(a_ovf_tracks_count, 1'b1, r_ovf == (r_rx_count > RX_CAP), "overflow flag out of step with receive count")
    `SEQ_ASSERT_NEXT(a_out_held, o_out_valid && !i_out_ready && !s_fire, o_out_valid && (r_res_cnt == $past(r_res_cnt)), "pending command lost while stalled")
    `SEQ_ASSERT_NOW(a_fire_room, s_fire, r_res_cnt <= 3'd1, "new command list loaded over pending commands")

endmodule
